/* src/frame_presentation_pacer_core_macros.svh */
// Assertion macros shared by the frame presentation pacer RTL.
`ifndef FRAME_PRESENTATION_PACER_CORE_MACROS_SVH
`define FRAME_PRESENTATION_PACER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/fpp_pkg.sv */
// Types and constants shared by the frame presentation pacer modules.
`timescale 1ns / 1ps

package fpp_pkg;

    localparam int STAMP_BITS = 32;
    localparam int CLOCK_BITS = 48;
    localparam int WAIT_BITS  = 32;
    localparam int COST_BITS  = 20;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_COST = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FALLBACK     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COST_LIMIT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LATE_LIMIT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_STEP     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_STEP     = 3'd5;

    localparam logic [1:0] ACT_FRAME   = 2'd0;
    localparam logic [1:0] ACT_WAKE    = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    localparam logic [1:0] MODE_PACED    = 2'd0;
    localparam logic [1:0] MODE_REANCHOR = 2'd1;
    localparam logic [1:0] MODE_FALLBACK = 2'd2;

    localparam logic [16:0] RST_INITIAL_COST = 17'd3000;
    localparam logic [19:0] RST_FALLBACK     = 20'd17000;
    localparam logic [19:0] RST_COST_LIMIT   = 20'd100000;
    localparam logic [23:0] RST_LATE_LIMIT   = 24'd250000;
    localparam logic [9:0]  RST_MIN_STEP     = 10'd2;
    localparam logic [15:0] RST_MAX_STEP     = 16'd1000;

    typedef struct packed {
        logic [1:0]            action;
        logic [STAMP_BITS-1:0] frame_time_ms;
        logic [CLOCK_BITS-1:0] clock_now_us;
    } t_in_item;

    typedef struct packed {
        logic [WAIT_BITS-1:0] wait_us;
        logic [1:0]           pacing_mode;
        logic [COST_BITS-1:0] cost_estimate_us;
    } t_out_item;

    typedef struct packed {
        logic [16:0] initial_cost_us;
        logic [19:0] fallback_wait_us;
        logic [19:0] cost_limit_us;
        logic [23:0] late_limit_us;
        logic [9:0]  min_step_ms;
        logic [15:0] max_step_ms;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* src/fpp_cfg_regs.sv */
// Configuration register file of the frame presentation pacer.
`timescale 1ns / 1ps

module fpp_cfg_regs
    import fpp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_wr_index,
    input  logic [CFG_DATA_W-1:0]  i_wr_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_cost_us  <= RST_INITIAL_COST;
            r_cfg.fallback_wait_us <= RST_FALLBACK;
            r_cfg.cost_limit_us    <= RST_COST_LIMIT;
            r_cfg.late_limit_us    <= RST_LATE_LIMIT;
            r_cfg.min_step_ms      <= RST_MIN_STEP;
            r_cfg.max_step_ms      <= RST_MAX_STEP;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                CFG_INITIAL_COST: r_cfg.initial_cost_us  <= i_wr_data[16:0];
                CFG_FALLBACK:     r_cfg.fallback_wait_us <= i_wr_data[19:0];
                CFG_COST_LIMIT:   r_cfg.cost_limit_us    <= i_wr_data[19:0];
                CFG_LATE_LIMIT:   r_cfg.late_limit_us    <= i_wr_data[23:0];
                CFG_MIN_STEP:     r_cfg.min_step_ms      <= i_wr_data[9:0];
                CFG_MAX_STEP:     r_cfg.max_step_ms      <= i_wr_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* src/fpp_pace_step.sv */
// Pacing state and the combinational computation of one item's result.
`timescale 1ns / 1ps

module fpp_pace_step
    import fpp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_go,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    localparam int SPAN_W = STAMP_BITS + 1;
    localparam int MUL_W  = SPAN_W + 10;
    localparam int TGT_W  = ((CLOCK_BITS > MUL_W) ? CLOCK_BITS : MUL_W) + 1;

    logic [STAMP_BITS-1:0] r_prev_frame, n_prev_frame;
    logic                  r_frame_valid, n_frame_valid;
    logic [STAMP_BITS-1:0] r_anchor_frame, n_anchor_frame;
    logic [CLOCK_BITS-1:0] r_anchor_wall, n_anchor_wall;
    logic                  r_anchor_valid, n_anchor_valid;
    logic [CLOCK_BITS-1:0] r_prev_wake, n_prev_wake;
    logic                  r_wake_valid, n_wake_valid;
    logic [COST_BITS-1:0]  r_avg, n_avg;

    logic [STAMP_BITS-1:0] ts;
    logic [CLOCK_BITS-1:0] now;
    logic [STAMP_BITS-1:0] step;
    logic                  in_range;
    logic [CLOCK_BITS-1:0] cost;
    logic                  cost_ok;
    logic [COST_BITS+1:0]  cost_sum;
    logic [COST_BITS-1:0]  avg_new;
    logic [STAMP_BITS-1:0] base;
    logic [CLOCK_BITS-1:0] wall;
    logic [STAMP_BITS+1:0] span_raw;
    logic [SPAN_W-1:0]     span;
    logic [MUL_W-1:0]      span_prod;
    logic [MUL_W-1:0]      step_prod;
    logic [TGT_W-1:0]      target;
    logic [TGT_W-1:0]      target_re;
    logic [TGT_W:0]        late_bound;
    logic                  is_late;
    logic [TGT_W-1:0]      wake;
    logic [TGT_W-1:0]      wait_full;
    logic [WAIT_BITS-1:0]  wait_sat;

    function automatic logic [TGT_W-1:0] less_cost(
        input logic [TGT_W-1:0]     tgt,
        input logic [COST_BITS-1:0] avg
    );
        logic [TGT_W-1:0] avg_ext;
        avg_ext = TGT_W'(avg);
        return (tgt > avg_ext) ? tgt - avg_ext : tgt;
    endfunction

    function automatic logic [MUL_W-1:0] times_1000(input logic [MUL_W-1:0] x);
        return (x << 10) - (x << 4) - (x << 3);
    endfunction

    assign ts   = i_item.frame_time_ms;
    assign now  = i_item.clock_now_us;
    assign step = ts - r_prev_frame;

    assign in_range = r_frame_valid && (ts > r_prev_frame)
                   && (step >= STAMP_BITS'(i_cfg.min_step_ms))
                   && (step <= STAMP_BITS'(i_cfg.max_step_ms));

    // Decode cost is the time from the last wake to this arrival.
    assign cost     = now - r_prev_wake;
    assign cost_ok  = r_wake_valid && (now > r_prev_wake)
                   && (cost <= CLOCK_BITS'(i_cfg.cost_limit_us));
    assign cost_sum = {1'b0, r_avg, 1'b0} + (COST_BITS+2)'(r_avg)
                    + (COST_BITS+2)'(cost[COST_BITS-1:0]);
    assign avg_new  = cost_ok ? cost_sum[COST_BITS+1:2] : r_avg;

    // An unanchored stream anchors at this frame before the target is formed.
    assign base = r_anchor_valid ? r_anchor_frame : ts;
    assign wall = r_anchor_valid ? r_anchor_wall : now;

    // Stream span is ts + step - base, clamped at zero.
    assign span_raw = {2'b00, ts} + {2'b00, step} - {2'b00, base};
    assign span     = span_raw[STAMP_BITS+1] ? '0 : span_raw[SPAN_W-1:0];

    assign span_prod  = times_1000(MUL_W'(span));
    assign step_prod  = times_1000(MUL_W'(step));
    assign target     = TGT_W'(wall) + TGT_W'(span_prod);
    assign target_re  = TGT_W'(now) + TGT_W'(step_prod);
    assign late_bound = (TGT_W+1)'(target) + (TGT_W+1)'(i_cfg.late_limit_us);
    assign is_late    = (TGT_W+1)'(now) > late_bound;

    assign wake      = is_late ? less_cost(target_re, avg_new) : less_cost(target, avg_new);
    assign wait_full = (wake > TGT_W'(now)) ? wake - TGT_W'(now) : '0;
    assign wait_sat  = (|wait_full[TGT_W-1:WAIT_BITS]) ? '1 : wait_full[WAIT_BITS-1:0];

    always_comb begin
        o_result.wait_us          = in_range ? wait_sat : WAIT_BITS'(i_cfg.fallback_wait_us);
        o_result.pacing_mode      = in_range ? (is_late ? MODE_REANCHOR : MODE_PACED)
                                             : MODE_FALLBACK;
        o_result.cost_estimate_us = in_range ? avg_new : r_avg;
    end

    always_comb begin
        n_prev_frame   = r_prev_frame;
        n_frame_valid  = r_frame_valid;
        n_anchor_frame = r_anchor_frame;
        n_anchor_wall  = r_anchor_wall;
        n_anchor_valid = r_anchor_valid;
        n_prev_wake    = r_prev_wake;
        n_wake_valid   = r_wake_valid;
        n_avg          = r_avg;
        if (i_go) begin
            unique case (i_item.action)
                ACT_FRAME: begin
                    n_prev_frame  = ts;
                    n_frame_valid = 1'b1;
                    if (in_range) begin
                        n_avg = avg_new;
                        if (is_late || !r_anchor_valid) begin
                            n_anchor_wall  = now;
                            n_anchor_frame = ts;
                        end
                        n_anchor_valid = 1'b1;
                    end else begin
                        n_anchor_wall  = '0;
                        n_anchor_frame = '0;
                        n_anchor_valid = 1'b0;
                    end
                end
                ACT_WAKE: begin
                    n_prev_wake  = now;
                    n_wake_valid = 1'b1;
                end
                ACT_RESTART: begin
                    n_prev_frame   = '0;
                    n_frame_valid  = 1'b0;
                    n_anchor_frame = '0;
                    n_anchor_wall  = '0;
                    n_anchor_valid = 1'b0;
                    n_prev_wake    = '0;
                    n_wake_valid   = 1'b0;
                    n_avg          = COST_BITS'(i_cfg.initial_cost_us);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_frame   <= '0;
            r_frame_valid  <= 1'b0;
            r_anchor_frame <= '0;
            r_anchor_wall  <= '0;
            r_anchor_valid <= 1'b0;
            r_prev_wake    <= '0;
            r_wake_valid   <= 1'b0;
            r_avg          <= COST_BITS'(RST_INITIAL_COST);
        end else begin
            r_prev_frame   <= n_prev_frame;
            r_frame_valid  <= n_frame_valid;
            r_anchor_frame <= n_anchor_frame;
            r_anchor_wall  <= n_anchor_wall;
            r_anchor_valid <= n_anchor_valid;
            r_prev_wake    <= n_prev_wake;
            r_wake_valid   <= n_wake_valid;
            r_avg          <= n_avg;
        end
    end

endmodule

/* src/fpp_out_queue.sv */
// Two-entry result queue that decouples the result stage from the receiver.
`timescale 1ns / 1ps

module fpp_out_queue
    import fpp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_data,
    input  logic      i_pop,
    output logic      o_valid,
    output t_out_item o_data,
    output t_q_status o_status
);

    t_out_item  r_slot [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid        = (r_count != 2'd0);
    assign o_data         = r_slot[r_rd_ptr];
    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);

endmodule

/* src/frame_presentation_pacer_core.sv */
// Top level of the frame presentation pacer.
`timescale 1ns / 1ps
`include "frame_presentation_pacer_core_macros.svh"

// Usage:
// Items enter on the input channel (i_in_valid, o_in_stall, i_in_item): a frame
// arrival, a wake after waiting, or a clock restart. Each frame transaction gives
// exactly one result transaction on the output channel (o_out_valid, i_out_stall,
// o_out_item) with the wait, the pacing mode and the averaged decode cost; wake
// and restart items give none. Registers are written through i_cfg_valid,
// o_cfg_ready, i_cfg_index and i_cfg_data; ready is always high, and writes are
// expected only while no item is in flight.
// A frame is held in the input register and its result is written into the result
// queue, which offers it. Throughput: one item per cycle while o_in_stall is low.
// The whole pacing step for an item is combinational between the input register and
// the result queue, since every item reads the state that the previous item leaves.
// Reset clears all pacing state, loads the register defaults and sets the cost
// average to the default initial cost. A stalled receiver fills the two-entry
// result queue; once it is full, a frame waiting in the input register holds and
// o_in_stall rises, while wake and restart items keep flowing.

module frame_presentation_pacer_core
    import fpp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_item               i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_item              o_out_item,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    t_cfg      cfg;
    t_out_item result;
    t_q_status q_status;
    logic      is_frame;
    logic      go;
    logic      push;
    logic      pop;

    assign o_cfg_ready = 1'b1;

    fpp_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Only a frame needs room in the result queue; other items always advance.
    assign is_frame   = (r_in_item.action == ACT_FRAME);
    assign o_in_stall = r_in_valid && is_frame && q_status.full;
    assign go         = r_in_valid && !o_in_stall;
    assign push       = go && is_frame;
    assign pop        = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    fpp_pace_step u_pace_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    fpp_out_queue u_out_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (result),
        .i_pop    (pop),
        .o_valid  (o_out_valid),
        .o_data   (o_out_item),
        .o_status (q_status)
    );

    `FPP_ASSERT_NEXT(a_frame_gives_result, i_clk, i_rst_n, push, o_out_valid, "frame result not offered")
    `FPP_ASSERT_SAME(a_no_push_when_full, i_clk, i_rst_n, q_status.full, !push, "push into full queue")
    `FPP_ASSERT_NEXT(a_pop_frees_slot, i_clk, i_rst_n, pop && !push, !q_status.full, "queue still full after pop")

endmodule
